FILE: src/udhg_pkg.sv
package udhg_pkg;

   localparam int SLOTS       = 20;
   localparam int GROUPS      = 30;
   localparam int DISCARD     = 1600;
   localparam int DISCARD_BLK = DISCARD / 8;

   localparam int SLOT_W  = 5;
   localparam int GRP_W   = 5;
   localparam int PRS_W   = 8;
   localparam int CELL_W  = 9;
   localparam int OFS_W   = 5;
   localparam int RED_W   = 9;
   localparam int QUO_W   = 5;
   localparam int LFSR_W  = 31;
   localparam int CNT_W   = 12;
   localparam int BLK_W   = CNT_W - 3;
   localparam int IDX_W   = 3;

   // csr register indexes
   localparam logic [IDX_W-1:0] REG_CELL_ID      = 3'd0;
   localparam logic [IDX_W-1:0] REG_GROUP_OFFSET = 3'd1;
   localparam logic [IDX_W-1:0] REG_GROUP_HOP_ON = 3'd2;
   localparam logic [IDX_W-1:0] REG_SEQ_HOP_ON   = 3'd3;
   localparam logic [IDX_W-1:0] REG_EXTENDED_CP  = 3'd4;

   typedef struct packed {
      logic             start;
      logic [RED_W-1:0] value;
   } red_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [GRP_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } red_stat_type;

   typedef struct packed {
      logic              load;
      logic              step;
      logic [LFSR_W-1:0] seed_a;
      logic [LFSR_W-1:0] seed_b;
   } lfsr_ctl_type;

endpackage

FILE: src/ul_dmrs_hopping_generator.sv
// Uplink DMRS group/sequence hopping generator.
// Input beat (req_valid/req_stall): a slot number. Output beat (rsp_valid/
// rsp_stall): slot echo, group number u, hopping bit v and the 8-bit n_PRS.
// The csr channel (csr_valid/csr_ready, always ready) writes cell id, group
// offset, the two hopping enables and the cyclic-prefix mode; write it only
// while no slot is in flight.
// One slot at a time: req_stall stays high from acceptance until its result
// has moved into the output register. The n_PRS byte lies 8*S*slot bits past
// the discard run (S = 6 or 7 symbols). Most of the work is the Gold LFSR
// stepper, which advances one bit per cycle through the 1600 discard steps
// and on to the end of the requested byte; both x2 registers run in parallel
// on a shared x1. The divide-by-30 unit is used three times in turn. Slots
// past the frame return at once with zero values.
// The output register holds a finished result while the receiver stalls;
// the next slot may already be computing behind it.
// Reset clears all csr registers to zero and empties both channels.
module ul_dmrs_hopping_generator #(
   parameter int SLOTS = udhg_pkg::SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [udhg_pkg::IDX_W-1:0]    csr_index,
   input  logic [udhg_pkg::CELL_W-1:0]   csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [udhg_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [udhg_pkg::SLOT_W-1:0]   rsp_slot_echo,
   output logic [udhg_pkg::GRP_W-1:0]    rsp_group_number,
   output logic                          rsp_seq_hop_bit,
   output logic [udhg_pkg::PRS_W-1:0]    rsp_prs_value
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIVC = 3'd1;
   localparam logic [2:0] ST_MODF = 3'd2;
   localparam logic [2:0] ST_RUN  = 3'd3;
   localparam logic [2:0] ST_SUMU = 3'd4;
   localparam logic [2:0] ST_MODU = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   localparam logic [udhg_pkg::SLOT_W-1:0] SLOT_LIM = udhg_pkg::SLOT_W'(SLOTS);
   localparam logic [udhg_pkg::BLK_W-1:0]  DISC_BLK =
      udhg_pkg::BLK_W'(udhg_pkg::DISCARD_BLK);
   localparam logic [udhg_pkg::CNT_W-1:0]  DISC_CNT = udhg_pkg::CNT_W'(udhg_pkg::DISCARD);

   // csr registers
   logic [udhg_pkg::CELL_W-1:0] cell_ff;
   logic [udhg_pkg::OFS_W-1:0]  ofs_ff;
   logic                        gh_ff, sh_ff, ecp_ff;

   logic [2:0]                  state_ff, state_in;
   logic [udhg_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [udhg_pkg::QUO_W-1:0]  q_ff, q_in;
   logic [udhg_pkg::GRP_W-1:0]  fss_ff, fss_in;
   logic [udhg_pkg::GRP_W-1:0]  u_ff, u_in;
   logic [udhg_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [udhg_pkg::BLK_W-1:0]  gh_blk_ff, gh_blk_in;
   logic [udhg_pkg::BLK_W-1:0]  prs_blk_ff, prs_blk_in;
   logic [udhg_pkg::CNT_W-1:0]  v_at_ff, v_at_in;
   logic [7:0]                  fgh_ff, fgh_in;
   logic [udhg_pkg::PRS_W-1:0]  prs_ff, prs_in;
   logic                        v_ff, v_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [udhg_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [udhg_pkg::GRP_W-1:0]  rsp_grp_ff;
   logic                        rsp_v_ff;
   logic [udhg_pkg::PRS_W-1:0]  rsp_prs_ff;

   udhg_pkg::red_ctl_type       red_ctl;
   udhg_pkg::red_stat_type      red_stat;
   udhg_pkg::lfsr_ctl_type      lfsr_ctl;
   logic                        bit_a, bit_b;

   logic                        req_acc, out_free, out_load;
   logic [7:0]                  sym_mul;
   logic                        in_gh, in_prs, run_end;

   udhg_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .ctl   (red_ctl),
      .stat  (red_stat)
   );

   udhg_gold u_gold (
      .clock (clock),
      .ctl   (lfsr_ctl),
      .bit_a (bit_a),
      .bit_b (bit_b)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign out_load  = (state_ff == ST_FIN) & out_free;

   // slot * symbols, block index of the n_PRS byte past the discard run
   assign sym_mul = 8'(req_slot) * (ecp_ff ? 8'd6 : 8'd7);
   assign in_gh   = (n_ff[udhg_pkg::CNT_W-1:3] == gh_blk_ff);
   assign in_prs  = (n_ff[udhg_pkg::CNT_W-1:3] == prs_blk_ff);
   assign run_end = in_prs & (n_ff[2:0] == 3'd7);

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      q_in       = q_ff;
      fss_in     = fss_ff;
      u_in       = u_ff;
      n_in       = n_ff;
      gh_blk_in  = gh_blk_ff;
      prs_blk_in = prs_blk_ff;
      v_at_in    = v_at_ff;
      fgh_in     = fgh_ff;
      prs_in     = prs_ff;
      v_in       = v_ff;
      red_ctl    = '0;
      lfsr_ctl   = '0;
      lfsr_ctl.seed_a = udhg_pkg::LFSR_W'(q_ff);
      lfsr_ctl.seed_b = udhg_pkg::LFSR_W'({q_ff, red_stat.rem});
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               slot_in    = req_slot;
               u_in       = '0;
               fgh_in     = '0;
               prs_in     = '0;
               v_in       = 1'b0;
               gh_blk_in  = DISC_BLK + udhg_pkg::BLK_W'(req_slot);
               prs_blk_in = DISC_BLK + udhg_pkg::BLK_W'(sym_mul);
               v_at_in    = DISC_CNT + udhg_pkg::CNT_W'(req_slot);
               if (req_slot >= SLOT_LIM) begin
                  state_in = ST_FIN;
               end else begin
                  red_ctl.start = 1'b1;
                  red_ctl.value = udhg_pkg::RED_W'(cell_ff);
                  state_in      = ST_DIVC;
               end
            end
         end
         ST_DIVC: begin
            if (red_stat.done) begin
               q_in          = red_stat.quo;
               red_ctl.start = 1'b1;
               red_ctl.value = udhg_pkg::RED_W'(red_stat.rem) + udhg_pkg::RED_W'(ofs_ff);
               state_in      = ST_MODF;
            end
         end
         ST_MODF: begin
            if (red_stat.done) begin
               fss_in        = red_stat.rem;
               lfsr_ctl.load = 1'b1;
               n_in          = '0;
               state_in      = ST_RUN;
            end
         end
         ST_RUN: begin
            lfsr_ctl.step = 1'b1;
            n_in          = n_ff + 1'b1;
            if (in_gh) begin
               fgh_in[n_ff[2:0]] = bit_a;
            end
            if (in_prs) begin
               prs_in[n_ff[2:0]] = bit_b;
            end
            if (n_ff == v_at_ff) begin
               v_in = bit_b;
            end
            if (run_end) begin
               state_in = ST_SUMU;
            end
         end
         ST_SUMU: begin
            red_ctl.start = 1'b1;
            red_ctl.value = (gh_ff ? udhg_pkg::RED_W'(fgh_ff) : '0)
                            + udhg_pkg::RED_W'(fss_ff);
            v_in          = v_ff & ~gh_ff & sh_ff;
            state_in      = ST_MODU;
         end
         ST_MODU: begin
            if (red_stat.done) begin
               u_in     = red_stat.rem;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cell_ff      <= '0;
         ofs_ff       <= '0;
         gh_ff        <= 1'b0;
         sh_ff        <= 1'b0;
         ecp_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid & csr_ready) begin
            case (csr_index)
               udhg_pkg::REG_CELL_ID:      cell_ff <= csr_wdata;
               udhg_pkg::REG_GROUP_OFFSET: ofs_ff  <= csr_wdata[udhg_pkg::OFS_W-1:0];
               udhg_pkg::REG_GROUP_HOP_ON: gh_ff   <= csr_wdata[0];
               udhg_pkg::REG_SEQ_HOP_ON:   sh_ff   <= csr_wdata[0];
               udhg_pkg::REG_EXTENDED_CP:  ecp_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
      slot_ff    <= slot_in;
      q_ff       <= q_in;
      fss_ff     <= fss_in;
      u_ff       <= u_in;
      n_ff       <= n_in;
      gh_blk_ff  <= gh_blk_in;
      prs_blk_ff <= prs_blk_in;
      v_at_ff    <= v_at_in;
      fgh_ff     <= fgh_in;
      prs_ff     <= prs_in;
      v_ff       <= v_in;
      if (out_load) begin
         rsp_slot_ff <= slot_ff;
         rsp_grp_ff  <= u_ff;
         rsp_v_ff    <= v_ff;
         rsp_prs_ff  <= prs_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_echo    = rsp_slot_ff;
   assign rsp_group_number = rsp_grp_ff;
   assign rsp_seq_hop_bit  = rsp_v_ff;
   assign rsp_prs_value    = rsp_prs_ff;

   a_acc_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("accepted slot did not start");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (n_ff[udhg_pkg::CNT_W-1:3] <= prs_blk_ff))
      else $error("lfsr run passed its last byte");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FIN) && !out_free) |=> (state_ff == ST_FIN))
      else $error("result dropped while output register full");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_grp_ff < udhg_pkg::GRP_W'(udhg_pkg::GROUPS)))
      else $error("group number out of range");

   a_reduce_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) || (state_ff == ST_RUN)) |-> !red_stat.busy)
      else $error("divider busy outside its phases");

endmodule

FILE: src/udhg_reduce.sv
// Iterative divide by 30: one compare-subtract per cycle.
module udhg_reduce (
   input  logic                   clock,
   input  logic                   reset,
   input  udhg_pkg::red_ctl_type  ctl,
   output udhg_pkg::red_stat_type stat
);

   localparam logic [udhg_pkg::RED_W-1:0] DIVISOR = udhg_pkg::RED_W'(udhg_pkg::GROUPS);

   logic [udhg_pkg::RED_W-1:0] val_ff, val_in;
   logic [udhg_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic                       busy_ff, busy_in;
   logic                       ge;

   assign ge = (val_ff >= DIVISOR);

   always_comb begin
      val_in  = val_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         val_in  = ctl.value;
         quo_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            val_in = val_ff - DIVISOR;
            quo_in = quo_ff + 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      val_ff <= val_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff & ~ge;
   assign stat.rem  = val_ff[udhg_pkg::GRP_W-1:0];
   assign stat.quo  = quo_ff;

endmodule

FILE: src/udhg_gold.sv
// Gold sequence stepper: one shared x1 register, two x2 registers.
module udhg_gold (
   input  logic                  clock,
   input  udhg_pkg::lfsr_ctl_type ctl,
   output logic                  bit_a,
   output logic                  bit_b
);

   logic [udhg_pkg::LFSR_W-1:0] x1_ff, x1_in;
   logic [udhg_pkg::LFSR_W-1:0] xa_ff, xa_in;
   logic [udhg_pkg::LFSR_W-1:0] xb_ff, xb_in;

   always_comb begin
      x1_in = x1_ff;
      xa_in = xa_ff;
      xb_in = xb_ff;
      if (ctl.load) begin
         x1_in = udhg_pkg::LFSR_W'(1);
         xa_in = ctl.seed_a;
         xb_in = ctl.seed_b;
      end else if (ctl.step) begin
         x1_in = {x1_ff[0] ^ x1_ff[3], x1_ff[udhg_pkg::LFSR_W-1:1]};
         xa_in = {xa_ff[0] ^ xa_ff[1] ^ xa_ff[2] ^ xa_ff[3], xa_ff[udhg_pkg::LFSR_W-1:1]};
         xb_in = {xb_ff[0] ^ xb_ff[1] ^ xb_ff[2] ^ xb_ff[3], xb_ff[udhg_pkg::LFSR_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      x1_ff <= x1_in;
      xa_ff <= xa_in;
      xb_ff <= xb_in;
   end

   assign bit_a = x1_ff[0] ^ xa_ff[0];
   assign bit_b = x1_ff[0] ^ xb_ff[0];

endmodule

FILE: bench/ul_dmrs_hopping_generator_tb.sv
`timescale 1ns / 100ps

module ul_dmrs_hopping_generator_tb;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int HOLD_CYCLES     = 8000;
   localparam int TAIL_CYCLES     = 3000;
   localparam int CYCLE_LIMIT     = 3_000_000;

   typedef struct packed {
      logic [udhg_pkg::SLOT_W-1:0] slot;
      logic [udhg_pkg::GRP_W-1:0]  grp;
      logic                        v;
      logic [udhg_pkg::PRS_W-1:0]  prs;
   } hop_beat_type;

   // directed stimulus: settings, slot, and a typed-in result where lit is set
   typedef struct packed {
      logic [udhg_pkg::CELL_W-1:0] cell_id;
      logic [udhg_pkg::OFS_W-1:0]  ofs;
      logic                        gh;
      logic                        sh;
      logic                        ecp;
      logic [udhg_pkg::SLOT_W-1:0] slot;
      logic                        lit;
      logic [udhg_pkg::GRP_W-1:0]  u;
      logic                        v;
      logic [udhg_pkg::PRS_W-1:0]  prs;
   } slot_row_type;

   localparam slot_row_type SLOT_ROWS [18] = '{
      '{9'd0,   5'd0,  1'b0, 1'b0, 1'b0, 5'd0,  1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd0,   5'd0,  1'b0, 1'b0, 1'b0, 5'd19, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd0,   5'd0,  1'b0, 1'b0, 1'b0, 5'd20, 1'b1, 5'd0, 1'b0, 8'd0},
      '{9'd0,   5'd0,  1'b0, 1'b0, 1'b0, 5'd31, 1'b1, 5'd0, 1'b0, 8'd0},
      '{9'd503, 5'd29, 1'b1, 1'b0, 1'b0, 5'd0,  1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd503, 5'd29, 1'b1, 1'b0, 1'b0, 5'd19, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd503, 5'd29, 1'b1, 1'b0, 1'b0, 5'd31, 1'b1, 5'd0, 1'b0, 8'd0},
      '{9'd503, 5'd29, 1'b0, 1'b1, 1'b1, 5'd0,  1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd503, 5'd29, 1'b0, 1'b1, 1'b1, 5'd19, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd511, 5'd31, 1'b1, 1'b1, 1'b1, 5'd19, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd511, 5'd31, 1'b1, 1'b1, 1'b1, 5'd7,  1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd511, 5'd31, 1'b1, 1'b1, 1'b1, 5'd24, 1'b1, 5'd0, 1'b0, 8'd0},
      '{9'd0,   5'd31, 1'b0, 1'b1, 1'b0, 5'd1,  1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd29,  5'd1,  1'b0, 1'b0, 1'b1, 5'd10, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd30,  5'd0,  1'b1, 1'b0, 1'b0, 5'd5,  1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd256, 5'd16, 1'b0, 1'b1, 1'b0, 5'd16, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd255, 5'd15, 1'b1, 1'b1, 1'b0, 5'd15, 1'b0, 5'd0, 1'b0, 8'd0},
      '{9'd255, 5'd15, 1'b1, 1'b1, 1'b0, 5'd20, 1'b1, 5'd0, 1'b0, 8'd0}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [udhg_pkg::IDX_W-1:0]    csr_index = '0;
   logic [udhg_pkg::CELL_W-1:0]   csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [udhg_pkg::SLOT_W-1:0]   req_slot = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [udhg_pkg::SLOT_W-1:0]   rsp_slot_echo;
   logic [udhg_pkg::GRP_W-1:0]    rsp_group_number;
   logic                          rsp_seq_hop_bit;
   logic [udhg_pkg::PRS_W-1:0]    rsp_prs_value;

   // register shadow, kept as ints so cell + offset cannot wrap
   int cfg_cell = 0;
   int cfg_ofs  = 0;
   int cfg_gh   = 0;
   int cfg_sh   = 0;
   int cfg_ecp  = 0;

   hop_beat_type expected_hops [$];
   int           err_cnt     = 0;
   int           n_checked   = 0;
   int           n_oob       = 0;
   int           n_settings  = 0;
   int           n_csr       = 0;
   int           cycle_cnt   = 0;
   int           tx_pct      = 0;
   int           rx_pct      = 0;
   logic         hold_armed  = 1'b0;
   logic         hold_on     = 1'b0;

   ul_dmrs_hopping_generator i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_slot         (req_slot),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_echo    (rsp_slot_echo),
      .rsp_group_number (rsp_group_number),
      .rsp_seq_hop_bit  (rsp_seq_hop_bit),
      .rsp_prs_value    (rsp_prs_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // count bits of c() from index first, after the discard run; bit i = c(first+i)
   function automatic logic [7:0] gold_window(input logic [udhg_pkg::LFSR_W-1:0] cinit,
                                              input int first, input int count);
      logic [udhg_pkg::LFSR_W-1:0] x1;
      logic [udhg_pkg::LFSR_W-1:0] x2;
      logic                        fb1;
      logic                        fb2;
      logic [7:0]                  acc;
      int                          n;
      x1  = 31'd1;
      x2  = cinit;
      acc = '0;
      for (n = 0; n < udhg_pkg::DISCARD + first + count; n++) begin
         if (n >= udhg_pkg::DISCARD + first) acc[n - udhg_pkg::DISCARD - first] = x1[0] ^ x2[0];
         fb1 = x1[0] ^ x1[3];
         fb2 = x2[0] ^ x2[1] ^ x2[2] ^ x2[3];
         x1  = {fb1, x1[udhg_pkg::LFSR_W-1:1]};
         x2  = {fb2, x2[udhg_pkg::LFSR_W-1:1]};
      end
      return acc;
   endfunction

   function automatic hop_beat_type predict_hops(input int slot);
      hop_beat_type r;
      int           fss;
      int           seed2;
      int           syms;
      int           fgh;
      logic [7:0]   vbits;
      r.slot = udhg_pkg::SLOT_W'(slot);
      r.grp  = '0;
      r.v    = 1'b0;
      r.prs  = '0;
      if (slot < udhg_pkg::SLOTS) begin
         fss   = (cfg_cell + cfg_ofs) % udhg_pkg::GROUPS;
         seed2 = 32 * (cfg_cell / udhg_pkg::GROUPS) + fss;
         syms  = cfg_ecp ? 6 : 7;
         fgh   = cfg_gh ? int'(gold_window(udhg_pkg::LFSR_W'(cfg_cell / udhg_pkg::GROUPS),
                                           8 * slot, 8)) : 0;
         r.grp = udhg_pkg::GRP_W'((fgh + fss) % udhg_pkg::GROUPS);
         if (!cfg_gh && cfg_sh) begin
            vbits = gold_window(udhg_pkg::LFSR_W'(seed2), slot, 1);
            r.v   = vbits[0];
         end
         r.prs = gold_window(udhg_pkg::LFSR_W'(seed2), 8 * syms * slot, 8);
      end
      return r;
   endfunction

   task automatic report_err(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      err_cnt++;
   endtask

   // all five registers in one burst; csr_valid stays high between beats
   task automatic write_config(input int cell_id, input int ofs, input int gh,
                               input int sh, input int ecp);
      logic [udhg_pkg::IDX_W-1:0]  regs [5];
      logic [udhg_pkg::CELL_W-1:0] vals [5];
      int                          i;
      regs = '{udhg_pkg::REG_CELL_ID, udhg_pkg::REG_GROUP_OFFSET, udhg_pkg::REG_GROUP_HOP_ON,
               udhg_pkg::REG_SEQ_HOP_ON, udhg_pkg::REG_EXTENDED_CP};
      vals = '{udhg_pkg::CELL_W'(cell_id), udhg_pkg::CELL_W'(ofs), udhg_pkg::CELL_W'(gh),
               udhg_pkg::CELL_W'(sh), udhg_pkg::CELL_W'(ecp)};
      for (i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         n_csr++;
         case (regs[i])
            udhg_pkg::REG_CELL_ID:      cfg_cell = int'(vals[i]);
            udhg_pkg::REG_GROUP_OFFSET: cfg_ofs  = int'(vals[i][udhg_pkg::OFS_W-1:0]);
            udhg_pkg::REG_GROUP_HOP_ON: cfg_gh   = int'(vals[i][0]);
            udhg_pkg::REG_SEQ_HOP_ON:   cfg_sh   = int'(vals[i][0]);
            udhg_pkg::REG_EXTENDED_CP:  cfg_ecp  = int'(vals[i][0]);
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic send_slot(input int slot, input hop_beat_type exp_beat);
      while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_slot  <= udhg_pkg::SLOT_W'(slot);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_hops.push_back(exp_beat);
      if (slot >= udhg_pkg::SLOTS) n_oob++;
   endtask

   // starts with an edge so req_valid is never lowered and raised in one step
   task automatic drain_hops();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_hops.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_pct);
      end
   end

   // long receiver hold-off, counted here
   initial begin
      wait (hold_armed);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   always @(posedge clock) begin
      hop_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hops.size() == 0) begin
            report_err($sformatf("unexpected beat, slot_echo %0d", rsp_slot_echo));
         end else begin
            e = expected_hops.pop_front();
            n_checked++;
            if (rsp_slot_echo !== e.slot)
               report_err($sformatf("slot_echo got %0d exp %0d", rsp_slot_echo, e.slot));
            if (rsp_group_number !== e.grp)
               report_err($sformatf("slot %0d group_number got %0d exp %0d",
                                    e.slot, rsp_group_number, e.grp));
            if (rsp_seq_hop_bit !== e.v)
               report_err($sformatf("slot %0d seq_hop_bit got %0d exp %0d",
                                    e.slot, rsp_seq_hop_bit, e.v));
            if (rsp_prs_value !== e.prs)
               report_err($sformatf("slot %0d prs_value got %0d exp %0d",
                                    e.slot, rsp_prs_value, e.prs));
         end
      end
   end

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycle_cnt, expected_hops.size());
      $display("FAIL ul_dmrs_hopping_generator");
      $finish;
   end

   initial begin
      int           p;
      int           k;
      int           slot;
      slot_row_type row;
      hop_beat_type lit_beat;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (SLOT_ROWS[r]) begin
         row = SLOT_ROWS[r];
         if (int'(row.cell_id) != cfg_cell || int'(row.ofs) != cfg_ofs ||
             int'(row.gh) != cfg_gh || int'(row.sh) != cfg_sh || int'(row.ecp) != cfg_ecp) begin
            drain_hops();
            write_config(row.cell_id, row.ofs, row.gh, row.sh, row.ecp);
         end
         lit_beat = '{row.slot, row.u, row.v, row.prs};
         send_slot(row.slot, row.lit ? lit_beat : predict_hops(row.slot));
      end

      for (p = 0; p < PHASES; p++) begin
         drain_hops();
         case (p)
            0: write_config(503, 29, 1, 1, 1);
            1: write_config(0, 0, 0, 1, 0);
            2: write_config(511, 31, 0, 1, 1);
            default:
               write_config(($urandom_range(9) == 0) ? $urandom_range(511, 504)
                                                     : $urandom_range(503),
                            ($urandom_range(9) == 0) ? $urandom_range(31, 30)
                                                     : $urandom_range(29),
                            $urandom_range(1), $urandom_range(1), $urandom_range(1));
         endcase
         case (p % 4)
            0: begin tx_pct = 0;  rx_pct <= 0;  end
            1: begin tx_pct = 70; rx_pct <= 0;  end
            2: begin tx_pct = 0;  rx_pct <= 70; end
            default: begin tx_pct = 23; rx_pct <= 23; end
         endcase
         // output register full and next slot done: input must back up
         if (p == 4) hold_armed <= 1'b1;
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (p == 5 && k == ITEMS_PER_PHASE / 2) drain_hops();
            slot = ($urandom_range(9) == 0) ? $urandom_range(31, udhg_pkg::SLOTS)
                                            : $urandom_range(udhg_pkg::SLOTS - 1);
            send_slot(slot, predict_hops(slot));
         end
      end

      drain_hops();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("checked %0d result beats (%0d out-of-frame slots) in %0d cycles",
               n_checked, n_oob, cycle_cnt);
      $display("%0d register settings via %0d csr beats, with idle/stall mixes and a long hold",
               n_settings, n_csr);
      if (err_cnt == 0) begin
         $display("PASS ul_dmrs_hopping_generator");
      end else begin
         $display("FAIL ul_dmrs_hopping_generator");
      end
      $finish;
   end

endmodule

FILE: ul_dmrs_hopping_generator.f
src/udhg_pkg.sv
src/udhg_reduce.sv
src/udhg_gold.sv
src/ul_dmrs_hopping_generator.sv
bench/ul_dmrs_hopping_generator_tb.sv
